// ===== hw/rtl/stk_pkg.sv =====
// Shared types and codes for the LIFO stack with search.
// No dependencies; used by the result channel interface and the top level.
`default_nettype none

package stk_pkg;

  // Operation codes carried in the func field
  typedef logic [1:0] func_t;
  localparam func_t FUNC_PUSH   = 2'd0;
  localparam func_t FUNC_POP    = 2'd1;
  localparam func_t FUNC_SEARCH = 2'd2;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // One result item as held in the output register
  typedef struct packed {
    status_e            status;
    logic signed [31:0] data;
    logic               found;
    logic               is_empty;
    logic               is_full;
    logic [7:0]         count;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stk_if.sv =====
// Valid/ready channel interfaces for stack requests and results.
// Depends on stk_pkg for the status type.
`default_nettype none

interface stk_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface stk_out_if
  import stk_pkg::*;
  ();
  logic               valid;
  logic               ready;
  status_e            status;
  logic signed [31:0] data;
  logic               found;
  logic               is_empty;
  logic               is_full;
  logic [7:0]         count;

  modport source (output valid, output status, output data, output found,
                  output is_empty, output is_full, output count, input ready);
  modport sink   (input valid, input status, input data, input found,
                  input is_empty, input is_full, input count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/stack_with_search.sv =====
// Top level of the LIFO stack with push, pop and linear search.
// Depends on stk_pkg and the channel interfaces in stk_if.sv.
//
//   channel  dir  modport  payload
//   in_i     in   sink     func, value
//   out_o    out  source   status, data, found, is_empty, is_full, count
//
// Push answers straight from idle; pop passes through S_POP for one
// synchronous read of the entry memory; search reads one entry at a time in
// S_SRCH up to and including a hit or the last held entry (none on an empty
// stack), since the entry memory has a single read port.
// Reset clears the fill count and the control state; the entry memory is
// not cleared. A new transaction is taken while the previous result is
// being taken at the same edge; a stalled result holds the block in idle.
`default_nettype none

module stack_with_search
  import stk_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  stk_in_if.sink    in_i,
  stk_out_if.source out_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]      scan_q, scan_d;
  logic signed [31:0] key_q, key_d;
  result_t            res_q, res_d;
  logic               res_vld_q, res_vld_d;

  // Entry memory
  logic [31:0]        mem [DEPTH];
  logic [31:0]        rdata_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;

  logic               accept, empty, full, hit, last;
  logic [CW-1:0]      cnt_m1;

  assign empty  = (cnt_q == '0);
  assign full   = (cnt_q == CW'(DEPTH));
  assign cnt_m1 = cnt_q - CW'(1);
  assign hit    = (rdata_q == key_q);
  assign last   = (scan_q == cnt_m1[AW-1:0]);

  assign in_i.ready = (state_q == S_IDLE) && (!res_vld_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  // Sequence each operation through the memory
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    scan_d    = scan_q;
    key_d     = key_q;
    res_d     = res_q;
    res_vld_d = res_vld_q && !out_o.ready;
    mem_we    = 1'b0;
    mem_waddr = cnt_q[AW-1:0];
    mem_re    = 1'b0;
    mem_raddr = scan_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.status = STATUS_OK;
          res_d.data   = '0;
          res_d.found  = 1'b0;
          key_d        = in_i.value;
          case (in_i.func)
            FUNC_PUSH: begin
              res_vld_d = 1'b1;
              if (full) begin
                res_d.status = STATUS_FULL;
              end else begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + CW'(1);
              end
            end
            FUNC_POP: begin
              if (empty) begin
                res_d.status = STATUS_EMPTY;
                res_vld_d    = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = cnt_m1[AW-1:0];
                cnt_d     = cnt_m1;
                state_d   = S_POP;
              end
            end
            FUNC_SEARCH: begin
              if (empty) begin
                res_vld_d = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                scan_d    = '0;
                state_d   = S_SRCH;
              end
            end
            default: begin
              res_vld_d = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        res_d.data = rdata_q;
        res_vld_d  = 1'b1;
        state_d    = S_IDLE;
      end
      S_SRCH: begin
        if (hit || last) begin
          res_d.found = hit;
          res_vld_d   = 1'b1;
          state_d     = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = scan_q + AW'(1);
          scan_d    = scan_q + AW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Flags always reflect the count after the operation
    res_d.is_empty = (cnt_d == '0);
    res_d.is_full  = (cnt_d == CW'(DEPTH));
    res_d.count    = 8'(cnt_d);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    key_q  <= key_d;
    res_q  <= res_d;
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= key_d;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Drive the result channel
  assign out_o.valid    = res_vld_q;
  assign out_o.status   = res_q.status;
  assign out_o.data     = res_q.data;
  assign out_o.found    = res_q.found;
  assign out_o.is_empty = res_q.is_empty;
  assign out_o.is_full  = res_q.is_full;
  assign out_o.count    = res_q.count;

endmodule

`default_nettype wire
